// ----- rtl/core/best_fit_heap_allocator_defines.svh -----
// assertion helpers used by the allocator top level
`ifndef BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// checked only while out of reset
`define BFHA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define BFHA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/core/bfha_pkg.sv -----
package bfha_pkg;

  // default geometry
  localparam int unsigned HEAP_UNITS_DEF = 4096;
  localparam int unsigned UNIT_BYTES_DEF = 16;

  // fixed field widths
  localparam int BYTES_W = 16;
  localparam int QUO_W   = 17;
  localparam int REM_W   = 6;

  // request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_WALK,
    S_ALLOC_HEAD,
    S_ALLOC_REST,
    S_FREE_HEAD,
    S_FREE_NEXT,
    S_FREE_WRITE,
    S_PREV,
    S_PREV_MERGE,
    S_RESULT
  } state_e;

  // divider status toward the controller
  typedef struct packed {
    logic               done;
    logic [QUO_W-1:0]   quo;
    logic [REM_W-1:0]   rem;
  } div_res_t;

endpackage

// ----- rtl/core/bfha_req_if.sv -----
interface bfha_req_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [bfha_pkg::BYTES_W-1:0]    request_bytes;
  logic [bfha_pkg::BYTES_W-1:0]    payload_offset_in;

  modport source (output valid, output func, output request_bytes,
                  output payload_offset_in, input ready);
  modport sink (input valid, input func, input request_bytes,
                input payload_offset_in, output ready);
endinterface

// ----- rtl/core/bfha_rsp_if.sv -----
interface bfha_rsp_if;
  logic                            valid;
  logic                            ready;
  bfha_pkg::status_e               status;
  logic [bfha_pkg::BYTES_W-1:0]    payload_offset;

  modport source (output valid, output status, output payload_offset, input ready);
  modport sink (input valid, input status, input payload_offset, output ready);
endinterface

// ----- rtl/core/bfha_ram.sv -----
module bfha_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = bfha_pkg::HEAP_UNITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ----- rtl/core/bfha_div.sv -----
module bfha_div #(
  parameter int unsigned UNIT_BYTES = bfha_pkg::UNIT_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bfha_pkg::QUO_W-1:0]   dividend_i,
  output bfha_pkg::div_res_t           res_o
);

  localparam int QW    = bfha_pkg::QUO_W;
  localparam int RW    = bfha_pkg::REM_W;
  // reciprocal is exact for dividends below 2**QW and divisors up to 2**RW
  localparam int SHIFT = QW + RW;
  localparam int MW    = SHIFT + 1;
  localparam int PRW   = QW + MW;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES);
  localparam logic [MW-1:0] RECIP   = MW'(RECIP_FULL);
  localparam logic [QW-1:0] DIVISOR = QW'(UNIT_BYTES);

  logic          mul_q;
  logic          sub_q;
  logic          done_q;
  logic [QW-1:0] num_q;
  logic [QW-1:0] quo_q;
  logic [RW-1:0] rem_q;

  // stage tracking: multiply, then remainder, then done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  // quotient by reciprocal multiply, remainder by multiply back and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (mul_q) begin
      quo_q <= QW'((PRW'(num_q) * PRW'(RECIP)) >> SHIFT);
    end
    if (sub_q) begin
      rem_q <= RW'(num_q - quo_q * DIVISOR);
    end
  end

  assign res_o.done = done_q;
  assign res_o.quo  = quo_q;
  assign res_o.rem  = rem_q;

endmodule

// ----- rtl/core/best_fit_heap_allocator.sv -----
// Best-fit heap allocator with block coalescing.
// req_i (sink) takes one word per request: func selects allocate or free,
// request_bytes is the allocation size, payload_offset_in the offset to free.
// rsp_o (source) returns one word per request: status and payload_offset.
// Both channels complete a transfer when valid and ready are high at a clock.
// After reset the header memory is swept once with req_i.ready low; the
// heap then holds one free block. One request is in flight at a time.
// An allocate divides, checks, walks B headers (one read per cycle from the
// single read port), writes the block header and, when the block is split,
// the remainder header. A free divides, checks, reads the freed header and,
// when a next block exists, its header, writes the freed header, walks the
// P blocks before the freed one and merges with the one before it if free.
// Zero-size and bad-offset requests go from the checks to the result, a
// free of a bad header after its read. The unit count comes from a
// reciprocal multiply. The next request is taken in the cycle after the
// word is loaded. The result sits in an output register; a new request is
// taken while it waits. When the receiver stalls, a finished second result
// holds the controller until the output register drains.
`include "best_fit_heap_allocator_defines.svh"

module best_fit_heap_allocator #(
  parameter int unsigned HEAP_UNITS = bfha_pkg::HEAP_UNITS_DEF,
  parameter int unsigned UNIT_BYTES = bfha_pkg::UNIT_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfha_req_if.sink   req_i,
  bfha_rsp_if.source rsp_o
);

  localparam int AW  = $clog2(HEAP_UNITS);
  localparam int AW1 = AW + 1;
  localparam int HW  = AW + 2;
  localparam int QW  = bfha_pkg::QUO_W;
  localparam int BW  = bfha_pkg::BYTES_W;
  localparam int PW  = AW + 8;
  localparam logic [AW1-1:0] HEAP_END = AW1'(HEAP_UNITS);
  localparam logic [AW-1:0]  LAST_UNIT = AW'(HEAP_UNITS - 1);
  localparam logic [HW-1:0]  INIT_HDR = {1'b1, 1'b0, LAST_UNIT};

  bfha_pkg::state_e   state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               func_q, func_d;
  logic [QW-1:0]      units_q, units_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [AW-1:0]      best_q, best_d;
  logic [AW-1:0]      best_size_q, best_size_d;
  logic               found_q, found_d;
  logic [AW-1:0]      h_q, h_d;
  logic [AW-1:0]      hsize_q, hsize_d;
  bfha_pkg::status_e  res_status_q, res_status_d;
  logic [BW-1:0]      res_off_q, res_off_d;

  logic               rsp_valid_q;
  bfha_pkg::status_e  rsp_status_q;
  logic [BW-1:0]      rsp_off_q;
  logic               rsp_load;
  logic               req_ready;

  // header memory port
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [HW-1:0]      rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [HW-1:0]      wr_data;

  // divider
  logic               div_start;
  logic [QW-1:0]      dividend;
  bfha_pkg::div_res_t div_res;

  // decoded header word and derived positions
  logic               hd_valid;
  logic               hd_alloc;
  logic [AW-1:0]      hd_size;
  logic [QW-1:0]      hd_size_ext;
  logic [AW1-1:0]     hd_end;
  logic [AW1-1:0]     rest_pos;
  logic [AW1-1:0]     best_inc;
  logic [PW-1:0]      off_prod;
  logic               split;
  logic               free_bad;

  assign {hd_valid, hd_alloc, hd_size} = rd_data;
  assign hd_size_ext = QW'(hd_size);
  assign hd_end      = {1'b0, pos_q} + {1'b0, hd_size} + AW1'(1);
  assign rest_pos    = {1'b0, best_q} + AW1'(units_q) + AW1'(1);
  assign best_inc    = {1'b0, best_q} + AW1'(1);
  assign off_prod    = PW'(best_inc) * PW'(UNIT_BYTES);
  assign split       = QW'(best_size_q) != units_q;
  assign free_bad    = (div_res.rem != '0) || (div_res.quo == '0)
                       || (div_res.quo > QW'(HEAP_UNITS));

  bfha_ram #(
    .WIDTH (HW),
    .DEPTH (HEAP_UNITS)
  ) u_hdr_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bfha_div #(
    .UNIT_BYTES (UNIT_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .res_o      (div_res)
  );

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfha_pkg::S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    units_q      <= units_d;
    pos_q        <= pos_d;
    best_q       <= best_d;
    best_size_q  <= best_size_d;
    found_q      <= found_d;
    h_q          <= h_d;
    hsize_q      <= hsize_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
  end

  // next state, memory accesses and divider start
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    func_d       = func_q;
    units_d      = units_q;
    pos_d        = pos_q;
    best_d       = best_q;
    best_size_d  = best_size_q;
    found_d      = found_q;
    h_d          = h_q;
    hsize_d      = hsize_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    div_start    = 1'b0;
    dividend     = QW'(req_i.payload_offset_in);
    rd_en        = 1'b0;
    rd_addr      = pos_q;
    wr_en        = 1'b0;
    wr_addr      = pos_q;
    wr_data      = '0;
    req_ready    = 1'b0;
    rsp_load     = 1'b0;

    unique case (state_q)
      // sweep the header memory after reset
      bfha_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = (clr_q == '0) ? INIT_HDR : '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == LAST_UNIT) begin
          state_d = bfha_pkg::S_IDLE;
        end
      end

      bfha_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_i.func == bfha_pkg::FUNC_ALLOC) begin
          dividend = QW'(req_i.request_bytes) + QW'(UNIT_BYTES - 1);
        end
        if (req_i.valid) begin
          func_d    = req_i.func;
          div_start = 1'b1;
          state_d   = bfha_pkg::S_DIV;
        end
      end

      bfha_pkg::S_DIV: begin
        if (div_res.done) begin
          state_d = bfha_pkg::S_CHECK;
        end
      end

      // size and offset checks, then first header read
      bfha_pkg::S_CHECK: begin
        res_off_d = '0;
        if (func_q == bfha_pkg::FUNC_ALLOC) begin
          if (div_res.quo == '0) begin
            res_status_d = bfha_pkg::ST_NOFIT;
            state_d      = bfha_pkg::S_RESULT;
          end else begin
            units_d = div_res.quo;
            pos_d   = '0;
            found_d = 1'b0;
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = bfha_pkg::S_WALK;
          end
        end else begin
          if (free_bad) begin
            res_status_d = bfha_pkg::ST_REJECT;
            state_d      = bfha_pkg::S_RESULT;
          end else begin
            h_d     = AW'(div_res.quo - QW'(1));
            pos_d   = AW'(div_res.quo - QW'(1));
            rd_en   = 1'b1;
            rd_addr = AW'(div_res.quo - QW'(1));
            state_d = bfha_pkg::S_FREE_HEAD;
          end
        end
      end

      // one header per cycle, best fit kept in registers
      bfha_pkg::S_WALK: begin
        if (!hd_alloc && hd_size_ext == units_q) begin
          best_d      = pos_q;
          best_size_d = hd_size;
          state_d     = bfha_pkg::S_ALLOC_HEAD;
        end else begin
          if (!hd_alloc && hd_size_ext > units_q
              && (!found_q || best_size_q > hd_size)) begin
            best_d      = pos_q;
            best_size_d = hd_size;
            found_d     = 1'b1;
          end
          if (hd_end < HEAP_END) begin
            pos_d   = AW'(hd_end);
            rd_en   = 1'b1;
            rd_addr = AW'(hd_end);
          end else if (found_d) begin
            state_d = bfha_pkg::S_ALLOC_HEAD;
          end else begin
            res_status_d = bfha_pkg::ST_NOFIT;
            state_d      = bfha_pkg::S_RESULT;
          end
        end
      end

      bfha_pkg::S_ALLOC_HEAD: begin
        wr_en        = 1'b1;
        wr_addr      = best_q;
        wr_data      = {1'b1, 1'b1, split ? AW'(units_q) : best_size_q};
        res_status_d = bfha_pkg::ST_DONE;
        res_off_d    = BW'(off_prod);
        state_d      = split ? bfha_pkg::S_ALLOC_REST : bfha_pkg::S_RESULT;
      end

      // remainder header after the split
      bfha_pkg::S_ALLOC_REST: begin
        if (rest_pos < HEAP_END) begin
          wr_en   = 1'b1;
          wr_addr = AW'(rest_pos);
          wr_data = {1'b1, 1'b0, best_size_q - AW'(units_q) - AW'(1)};
        end
        state_d = bfha_pkg::S_RESULT;
      end

      bfha_pkg::S_FREE_HEAD: begin
        if (!hd_valid || !hd_alloc) begin
          res_status_d = bfha_pkg::ST_REJECT;
          state_d      = bfha_pkg::S_RESULT;
        end else begin
          res_status_d = bfha_pkg::ST_DONE;
          hsize_d      = hd_size;
          if (hd_end < HEAP_END) begin
            pos_d   = AW'(hd_end);
            rd_en   = 1'b1;
            rd_addr = AW'(hd_end);
            state_d = bfha_pkg::S_FREE_NEXT;
          end else begin
            state_d = bfha_pkg::S_FREE_WRITE;
          end
        end
      end

      // absorb a free next block
      bfha_pkg::S_FREE_NEXT: begin
        if (!hd_alloc) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = {1'b0, hd_alloc, hd_size};
          hsize_d = hsize_q + hd_size + AW'(1);
        end
        state_d = bfha_pkg::S_FREE_WRITE;
      end

      bfha_pkg::S_FREE_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = h_q;
        wr_data = {1'b1, 1'b0, hsize_q};
        if (h_q == '0) begin
          state_d = bfha_pkg::S_RESULT;
        end else begin
          pos_d   = '0;
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = bfha_pkg::S_PREV;
        end
      end

      // walk from the heap start to the block ending at the freed header
      bfha_pkg::S_PREV: begin
        if (hd_end == {1'b0, h_q}) begin
          if (!hd_alloc) begin
            wr_en   = 1'b1;
            wr_addr = pos_q;
            wr_data = {hd_valid, 1'b0, hd_size + hsize_q + AW'(1)};
            state_d = bfha_pkg::S_PREV_MERGE;
          end else begin
            state_d = bfha_pkg::S_RESULT;
          end
        end else if (hd_end < {1'b0, h_q}) begin
          pos_d   = AW'(hd_end);
          rd_en   = 1'b1;
          rd_addr = AW'(hd_end);
        end else begin
          state_d = bfha_pkg::S_RESULT;
        end
      end

      bfha_pkg::S_PREV_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = h_q;
        wr_data = {1'b0, 1'b0, hsize_q};
        state_d = bfha_pkg::S_RESULT;
      end

      bfha_pkg::S_RESULT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = bfha_pkg::S_IDLE;
        end
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_off_q    <= res_off_q;
    end
  end

  assign req_i.ready          = req_ready;
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.payload_offset = rsp_off_q;

  // checks
  `BFHA_ASSERT(a_div_done_in_div, div_res.done |-> state_q == bfha_pkg::S_DIV, "divider done outside divide state")
  `BFHA_ASSERT(a_fail_no_offset, rsp_valid_q && rsp_status_q != bfha_pkg::ST_DONE |-> rsp_off_q == '0, "failed request carries an offset")
  `BFHA_ASSERT(a_no_rw_overlap, wr_en && rd_en |-> wr_addr != rd_addr, "header read and write collide")
  `BFHA_ASSERT_ALWAYS(a_clear_exit, !rst_ni || $past(state_q) != bfha_pkg::S_CLEAR || state_q == bfha_pkg::S_CLEAR || state_q == bfha_pkg::S_IDLE, "sweep left to a busy state")

endmodule
